// ===== sv/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants for the closest pair distance block.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int Q8_BITS    = (SQ_BITS + 1) / 2 + 8;
    localparam int PAIRS      = Q8_BITS;
    localparam int REM_BITS   = Q8_BITS + 2;
    localparam int STEP_BITS  = $clog2(PAIRS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_STORE,
        ST_SQRT,
        ST_OUT
    } cpd_state_t;

    // controller -> datapath
    typedef struct packed {
        logic                 take_point;
        logic                 clr_scan;
        logic                 scan_step;
        logic                 store_point;
        logic                 mark_drop;
        logic                 sqrt_start;
        logic                 sqrt_step;
        logic                 load_result;
        logic                 clear_set;
    } cpd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic                 set_full;
        logic                 scan_done;
        logic                 pipe_empty;
        logic                 sqrt_done;
        logic                 last_flag;
    } cpd_stat_t;

endpackage

// ===== sv/cpd_if.sv =====
// ----------------------------------------------------------------------------
// cpd_if
// Valid/ready channel carrying one word of payload.
// ----------------------------------------------------------------------------
interface cpd_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/cpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpd_ctrl
// Sequencer: scan stored points, store or drop (set full) the new point, then root and output on last.
// ----------------------------------------------------------------------------
module cpd_ctrl
    import cpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    input  cpd_stat_t stat,
    output cpd_cmd_t  cmd
);

    cpd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.set_full)
                begin
                    state_next = stat.last_flag ? ST_SQRT : ST_IDLE;
                end
                else if (stat.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                state_next = stat.last_flag ? ST_SQRT : ST_IDLE;
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.take_point = in_valid;
                cmd.clr_scan   = in_valid;
            end
            ST_SCAN:
            begin
                cmd.mark_drop  = stat.set_full;
                cmd.scan_step  = !stat.set_full && !stat.scan_done;
                cmd.sqrt_start = stat.set_full && stat.last_flag;
            end
            ST_DRAIN:
            begin
                cmd.scan_step = 1'b0;
            end
            ST_STORE:
            begin
                cmd.store_point = 1'b1;
                cmd.sqrt_start  = stat.last_flag;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = !stat.sqrt_done;
            end
            ST_OUT:
            begin
                cmd.load_result = out_free;
                cmd.clear_set   = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> state_reg == ST_IDLE)
        else $error("result load did not end set");
    a_sqrt_from: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_SQRT) |-> $past(stat.last_flag))
        else $error("root started without last point");

endmodule

// ===== sv/cpd_dp.sv =====
// ----------------------------------------------------------------------------
// cpd_dp
// Point store, distance pipeline with separate x and y squarers, min tracker, root unit.
// ----------------------------------------------------------------------------
module cpd_dp
    import cpd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic                         in_last,
    input  cpd_cmd_t                     cmd,
    output cpd_stat_t                    stat,
    output logic        [SQ_BITS-1:0]    res_sq,
    output logic        [Q8_BITS-1:0]    res_q8,
    output logic                         res_no_pair,
    output logic                         res_over
);

    logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic                         last_reg;
    logic [CNT_BITS-1:0]          count_reg;
    logic [CNT_BITS-1:0]          scan_reg;
    logic [SQ_BITS-1:0]           best_reg;
    logic                         drop_reg;

    // pipeline: read -> diff -> square -> sum/compare
    logic                         v_rd_reg, v_df_reg, v_sq_reg;
    logic signed [COORD_BITS-1:0] rx_reg, ry_reg;
    logic [DIFF_BITS-1:0]         dx_reg, dy_reg;
    logic [PROD_BITS-1:0]         ax_reg, ay_reg;

    logic [DIFF_BITS-1:0] dx_next, dy_next;
    logic [SQ_BITS-1:0]   sum;

    // root unit
    logic [SQ_BITS:0]     rv_reg;
    logic [Q8_BITS-1:0]   root_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [1:0]           two;
    logic [REM_BITS-1:0]  rem_sh, trial;

    always_ff @(posedge clk)
    begin
        if (cmd.store_point)
        begin
            x_mem[count_reg[IDX_BITS-1:0]] <= px_reg;
            y_mem[count_reg[IDX_BITS-1:0]] <= py_reg;
        end
        rx_reg <= x_mem[scan_reg[IDX_BITS-1:0]];
        ry_reg <= y_mem[scan_reg[IDX_BITS-1:0]];
    end

    always_comb
    begin
        if (px_reg >= rx_reg)
        begin
            dx_next = DIFF_BITS'({px_reg[COORD_BITS-1], px_reg})
                    - DIFF_BITS'({rx_reg[COORD_BITS-1], rx_reg});
        end
        else
        begin
            dx_next = DIFF_BITS'({rx_reg[COORD_BITS-1], rx_reg})
                    - DIFF_BITS'({px_reg[COORD_BITS-1], px_reg});
        end
        if (py_reg >= ry_reg)
        begin
            dy_next = DIFF_BITS'({py_reg[COORD_BITS-1], py_reg})
                    - DIFF_BITS'({ry_reg[COORD_BITS-1], ry_reg});
        end
        else
        begin
            dy_next = DIFF_BITS'({ry_reg[COORD_BITS-1], ry_reg})
                    - DIFF_BITS'({py_reg[COORD_BITS-1], py_reg});
        end
        sum = {1'b0, ax_reg} + {1'b0, ay_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_point)
        begin
            px_reg   <= in_x;
            py_reg   <= in_y;
            last_reg <= in_last;
        end
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        // magnitudes fit in COORD_BITS, so the square fits in PROD_BITS
        ax_reg <= PROD_BITS'(dx_reg) * PROD_BITS'(dx_reg);
        ay_reg <= PROD_BITS'(dy_reg) * PROD_BITS'(dy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            scan_reg  <= '0;
            best_reg  <= '1;
            drop_reg  <= 1'b0;
            v_rd_reg  <= 1'b0;
            v_df_reg  <= 1'b0;
            v_sq_reg  <= 1'b0;
        end
        else
        begin
            v_rd_reg <= cmd.scan_step;
            v_df_reg <= v_rd_reg;
            v_sq_reg <= v_df_reg;
            if (cmd.clr_scan)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (v_sq_reg && sum < best_reg)
            begin
                best_reg <= sum;
            end
            if (cmd.store_point)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.mark_drop)
            begin
                drop_reg <= 1'b1;
            end
            if (cmd.clear_set)
            begin
                count_reg <= '0;
                best_reg  <= '1;
                drop_reg  <= 1'b0;
            end
        end
    end

    // digit-by-digit root, two radicand bits per step, radicand = best * 2^16
    always_comb
    begin
        two    = rv_reg[SQ_BITS -: 2];
        rem_sh = {rem_reg[REM_BITS-3:0], two};
        trial  = REM_BITS'({root_reg, 2'b01});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            root_reg <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
            // odd width: pad one zero bit on top so pairs align
            rv_reg   <= {1'b0, best_reg};
        end
        else if (cmd.sqrt_step)
        begin
            rv_reg   <= {rv_reg[SQ_BITS-2:0], 2'b00};
            step_reg <= step_reg + 1'b1;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[Q8_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[Q8_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            res_no_pair <= (count_reg < CNT_BITS'(2));
            res_sq      <= (count_reg < CNT_BITS'(2)) ? '0 : best_reg;
            res_q8      <= (count_reg < CNT_BITS'(2)) ? '0 : root_reg;
            res_over    <= drop_reg;
        end
    end

    assign stat.set_full   = (count_reg == CNT_BITS'(MAX_POINTS));
    assign stat.scan_done  = (scan_reg == count_reg);
    assign stat.pipe_empty = !v_rd_reg && !v_df_reg && !v_sq_reg;
    assign stat.sqrt_done  = (step_reg == STEP_BITS'(PAIRS));
    assign stat.last_flag  = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_POINTS))
        else $error("point count past capacity");
    a_best_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_set |=> best_reg == '1 && count_reg == '0)
        else $error("set not cleared");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> scan_reg < count_reg)
        else $error("scan past stored points");

endmodule

// ===== sv/closest_pair_distance.sv =====
// ----------------------------------------------------------------------------
// closest_pair_distance
// Streaming closest pair of 2-D points with squared and Q.8 root distance.
// ----------------------------------------------------------------------------
// Each point word is compared with every stored point of the current set, one
// distance per cycle through a pipelined pair of squarers. The word marked
// last then runs a radix-4 root unit over 25 steps, and the result word is
// held in an output register until taken. A point that comes when the set is
// full is dropped and flagged. The set clears after each result.
module closest_pair_distance
    import cpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cpd_if.sink  in_ch,
    cpd_if.source out_ch
);

    cpd_cmd_t  cmd;
    cpd_stat_t stat;
    logic      in_ready;
    logic      out_valid_reg;
    logic      out_free;

    logic [SQ_BITS-1:0] res_sq;
    logic [Q8_BITS-1:0] res_q8;
    logic               res_no_pair, res_over;

    assign out_free       = !out_valid_reg || out_ch.ready;
    assign in_ch.ready    = in_ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.data.min_dist_sq = res_sq;
    assign out_ch.data.min_dist_q8 = res_q8;
    assign out_ch.data.no_pair     = res_no_pair;
    assign out_ch.data.overflowed  = res_over;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    cpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    cpd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_x        (in_ch.data.point_x),
        .in_y        (in_ch.data.point_y),
        .in_last     (in_ch.data.last_point),
        .cmd         (cmd),
        .stat        (stat),
        .res_sq      (res_sq),
        .res_q8      (res_q8),
        .res_no_pair (res_no_pair),
        .res_over    (res_over)
    );

endmodule

// ===== tb/sv/closest_pair_distance_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_distance_test
// Streams sets of 2-D points into the block, predicts the closest squared
// distance, its Q.8 root and the flags per set, and compares every result
// word against the prediction under random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
module closest_pair_distance_test;
    import cpd_pkg::*;

    localparam int SQ_W = 2 * COORD_BITS + 1;
    localparam int Q8_W = (SQ_W + 1) / 2 + 8;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } point_word_t;

    typedef struct packed {
        logic [SQ_W-1:0] min_dist_sq;
        logic [Q8_W-1:0] min_dist_q8;
        logic            no_pair;
        logic            overflowed;
    } dist_word_t;

    class pair_scoreboard;
        longint      xs[MAX_POINTS];
        longint      ys[MAX_POINTS];
        int          count;
        logic [63:0] best;
        bit          dropped;
        dist_word_t  expected_q[$];
        int          errors;

        function new();
            count = 0;
            best = (64'd1 << SQ_W) - 1;
            dropped = 0;
            errors = 0;
        endfunction

        // floor(sqrt(v * 65536)) by bisection on the root
        function logic [Q8_W-1:0] root_q8(logic [63:0] v);
            logic [63:0] target;
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] mid;
            target = v << 16;
            lo = 0;
            hi = (64'd1 << Q8_W) - 1;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid <= target)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo[Q8_W-1:0];
        endfunction

        function void note_point(point_word_t p);
            longint     px;
            longint     py;
            longint     dx;
            longint     dy;
            logic [63:0] s;
            dist_word_t r;
            px = longint'(p.point_x);
            py = longint'(p.point_y);
            if (count < MAX_POINTS) begin
                for (int i = 0; i < count; i++) begin
                    dx = px - xs[i];
                    dy = py - ys[i];
                    s = dx * dx + dy * dy;
                    if (s > (64'd1 << SQ_W) - 1)
                        s = (64'd1 << SQ_W) - 1;
                    if (s < best)
                        best = s;
                end
                xs[count] = px;
                ys[count] = py;
                count++;
            end
            else
                dropped = 1;
            if (p.last_point) begin
                if (count < 2) begin
                    r.min_dist_sq = '0;
                    r.min_dist_q8 = '0;
                    r.no_pair = 1;
                end
                else begin
                    r.min_dist_sq = best[SQ_W-1:0];
                    r.min_dist_q8 = root_q8(best);
                    r.no_pair = 0;
                end
                r.overflowed = dropped;
                expected_q.push_back(r);
                count = 0;
                best = (64'd1 << SQ_W) - 1;
                dropped = 0;
            end
        endfunction

        function void check_result(dist_word_t got);
            dist_word_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: sq=%0d q8=%0d np=%0d ov=%0d",
                             got.min_dist_sq, got.min_dist_q8, got.no_pair,
                             got.overflowed);
                return;
            end
            e = expected_q.pop_front();
            if (got.min_dist_sq !== e.min_dist_sq || got.min_dist_q8 !== e.min_dist_q8
                || got.no_pair !== e.no_pair || got.overflowed !== e.overflowed) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp sq=%0d q8=%0d np=%0d ov=%0d, got sq=%0d q8=%0d np=%0d ov=%0d",
                             e.min_dist_sq, e.min_dist_q8, e.no_pair, e.overflowed,
                             got.min_dist_sq, got.min_dist_q8, got.no_pair,
                             got.overflowed);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;

    cpd_if #(.payload_t(point_word_t)) in_ch ();
    cpd_if #(.payload_t(dist_word_t))  out_ch ();

    closest_pair_distance uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #2 clk = ~clk;

    pair_scoreboard sb = new();
    int             burst_left = 0;
    int             points_sent = 0;

    initial
    begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_point(in_ch.data);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);
    end

    // receiver: random stall pattern, one long hold-off early in the run
    initial
    begin
        int cyc;
        int hold;
        cyc = 0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 400)
                hold = 3000;
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 0;
            end
            else if ((cyc / 200) % 3 == 0)
                out_ch.ready <= 1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_point(logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y, logic last);
        point_word_t p;
        int          gap;
        p.point_x = x;
        p.point_y = y;
        p.last_point = last;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_ch.valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1;
        in_ch.data <= p;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        points_sent++;
    endtask

    task automatic send_set(int n, bit clustered);
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        bx = $urandom;
        by = $urandom;
        for (int i = 0; i < n; i++)
        begin
            if (clustered)
                send_point(bx + $urandom_range(0, 15), by - $urandom_range(0, 15),
                           i == n - 1);
            else
                send_point($urandom, $urandom, i == n - 1);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // single point: no pair
        send_point(16'sd0, 16'sd0, 1);
        // opposite corners: largest distance
        send_point(-16'sd32768, -16'sd32768, 0);
        send_point(16'sd32767, 16'sd32767, 1);
        send_point(16'sd32767, -16'sd32768, 0);
        send_point(-16'sd32768, 16'sd32767, 1);
        // duplicates give zero
        send_point(16'sd5, -16'sd7, 0);
        send_point(16'sd5, -16'sd7, 0);
        send_point(16'sd100, 16'sd3, 1);
        send_point(16'sd1, 16'sd0, 0);
        send_point(16'sd0, 16'sd1, 1);
        send_point(-16'sd1, -16'sd1, 0);
        send_point(16'sd0, 16'sd0, 0);
        send_point(16'sd32767, 16'sd0, 1);
        // full set then a dropped point that ends the set
        send_set(MAX_POINTS + 1, 0);
        send_set(MAX_POINTS + 3, 1);

        while (points_sent < 650)
        begin
            if ($urandom_range(0, 24) == 0)
                send_set($urandom_range(MAX_POINTS - 4, MAX_POINTS + 4),
                         $urandom_range(0, 1));
            else
                send_set($urandom_range(1, 8), $urandom_range(0, 1));
        end
        in_ch.valid <= 0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/cpd_pkg.sv
sv/cpd_if.sv
sv/cpd_ctrl.sv
sv/cpd_dp.sv
sv/closest_pair_distance.sv
tb/sv/closest_pair_distance_test.sv
